[src/rnta_pkg.sv]
// ============================================================================
// rnta_pkg - shared types and constants for the radix number to ASCII block
// Character codes, radix and register codes, the job descriptor passed from
// the front end to the back end, and the digit-to-character mapping.
// ============================================================================
package rnta_pkg;

   localparam int DefaultValueWidth = 32;
   localparam int QueueDepth        = 2;
   localparam int QueueCountWidth   = $clog2(QueueDepth + 1);
   localparam int CharWidth         = 7;
   localparam int DigitWidth        = 4;

   typedef logic [CharWidth-1:0]  char_type;
   typedef logic [DigitWidth-1:0] digit_type;

   // first digit value that prints as a letter
   localparam digit_type LetterFirstDigit = 4'd10;

   localparam char_type CharZero    = 7'h30;
   localparam char_type CharUpperA  = 7'h41;
   localparam char_type CharLowerA  = 7'h61;
   localparam char_type CharDollar  = 7'h24;
   localparam char_type CharAt      = 7'h40;
   localparam char_type CharPercent = 7'h25;
   localparam char_type CharMinus   = 7'h2D;
   localparam char_type CharUpperH  = 7'h48;
   localparam char_type CharUpperO  = 7'h4F;
   localparam char_type CharUpperB  = 7'h42;
   localparam char_type CharLowerH  = 7'h68;
   localparam char_type CharLowerO  = 7'h6F;
   localparam char_type CharLowerB  = 7'h62;

   typedef enum logic [2:0] {
      RC_HEX    = 3'd0,
      RC_OCT    = 3'd1,
      RC_BIN    = 3'd2,
      RC_DEC    = 3'd3,
      RC_SDEC   = 3'd4,
      RC_HEX_NP = 3'd5,
      RC_OCT_NP = 3'd6,
      RC_BIN_NP = 3'd7
   } radix_code_type;

   typedef enum logic [0:0] {
      CSR_UPPERCASE    = 1'b0,
      CSR_SYNTAX_STYLE = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      STYLE_PREFIX = 1'b0,
      STYLE_SUFFIX = 1'b1
   } syntax_style_type;

   // digit size used by the back end; decimal runs through BCD as hex
   typedef enum logic [1:0] {
      DK_HEX = 2'd0,
      DK_OCT = 2'd1,
      DK_BIN = 2'd2
   } digit_kind_type;

   typedef struct packed {
      logic           is_dec;
      digit_kind_type kind;
      logic           pre_valid;
      logic           pre_if_letter;
      char_type       pre_char;
      logic           post_valid;
      char_type       post_char;
   } job_ctl_type;

   typedef struct packed {
      logic                       full;
      logic                       empty;
      logic [QueueCountWidth-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic idle;
   } back_status_type;

   function automatic logic [4:0] base_of(radix_code_type code);
      logic [4:0] base;
      unique case (code)
         RC_HEX, RC_HEX_NP: base = 5'd16;
         RC_OCT, RC_OCT_NP: base = 5'd8;
         RC_BIN, RC_BIN_NP: base = 5'd2;
         default:           base = 5'd10;
      endcase
      return base;
   endfunction

   // relaxed signed range upper bound: min(base, 10)
   function automatic logic [4:0] relax_limit_of(radix_code_type code);
      logic [4:0] limit;
      unique case (code)
         RC_OCT, RC_OCT_NP: limit = 5'd8;
         RC_BIN, RC_BIN_NP: limit = 5'd2;
         default:           limit = 5'd10;
      endcase
      return limit;
   endfunction

   function automatic char_type digit_char(digit_type d, logic upper);
      char_type c;
      if (d < LetterFirstDigit) begin
         c = CharZero + {3'b000, d};
      end else begin
         c = (upper ? CharUpperA : CharLowerA) + {3'b000, d - LetterFirstDigit};
      end
      return c;
   endfunction

endpackage

[src/radix_number_to_ascii.sv]
// ============================================================================
// radix_number_to_ascii - number to ASCII text in a chosen radix
// Request beats carry a value, radix code, relax flag and operand width;
// response beats carry the text one character at a time, top digit first.
// ============================================================================
//
// Each request beat is turned into a stream of response beats, one ASCII
// character per beat, the final one marked by rsp_last_char. The front end
// classifies a request in the accept cycle and parks it in a two-deep job
// queue, so new requests are taken while the back end is still printing.
// The back end handles one number at a time: it picks up a job, runs
// binary-to-BCD conversion for the decimal forms, fills the digit store
// digit by digit, passes the sign or prefix slot, then sends one beat per
// digit and one for a suffix. The digit store has a single write port,
// used during generation, and a single read port, used during output.
// Output backpressure stalls only the read-out; the output register and a
// read stage keep one beat per cycle flowing while rsp_ready is high. The
// uppercase and syntax_style registers are written through the csr port
// and must only change while no number is in flight.
//
module radix_number_to_ascii import rnta_pkg::*; #(
   parameter int VALUE_WIDTH = DefaultValueWidth
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [2:0]             req_radix_code,
   input  logic                   req_relax,
   input  logic [5:0]             req_bit_width,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CharWidth-1:0]   rsp_char_code,
   output logic                   rsp_last_char,
   // register write port
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  logic                   csr_write_data
);

   localparam int CntWidth   = $clog2(VALUE_WIDTH + 1);
   localparam int QueueWidth = VALUE_WIDTH + CntWidth + $bits(job_ctl_type);

   // configuration registers
   logic             uppercase_ff,    uppercase_in;
   syntax_style_type syntax_style_ff, syntax_style_in;

   // front to queue
   logic                   q_push;
   logic [VALUE_WIDTH-1:0] push_value;
   logic [CntWidth-1:0]    push_pad;
   job_ctl_type            push_ctl;
   logic [QueueWidth-1:0]  push_data;

   // queue to back
   logic                   q_pop;
   logic [QueueWidth-1:0]  pop_data;
   logic [VALUE_WIDTH-1:0] pop_value;
   logic [CntWidth-1:0]    pop_pad;
   job_ctl_type            pop_ctl;
   queue_status_type       q_stat;
   back_status_type        b_stat;

   always_comb begin
      uppercase_in    = uppercase_ff;
      syntax_style_in = syntax_style_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_UPPERCASE:    uppercase_in    = csr_write_data;
            CSR_SYNTAX_STYLE: syntax_style_in = syntax_style_type'(csr_write_data);
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uppercase_ff    <= 1'b0;
         syntax_style_ff <= STYLE_PREFIX;
      end else begin
         uppercase_ff    <= uppercase_in;
         syntax_style_ff <= syntax_style_in;
      end
   end

   rnta_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_radix_code (req_radix_code),
      .req_relax      (req_relax),
      .req_bit_width  (req_bit_width),
      .uppercase      (uppercase_ff),
      .syntax_style   (syntax_style_ff),
      .q_stat         (q_stat),
      .push           (q_push),
      .push_value     (push_value),
      .push_pad       (push_pad),
      .push_ctl       (push_ctl)
   );

   assign push_data = {push_value, push_pad, push_ctl};

   rnta_queue #(
      .DATA_WIDTH (QueueWidth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   assign {pop_value, pop_pad, pop_ctl} = pop_data;

   rnta_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .uppercase     (uppercase_ff),
      .q_stat        (q_stat),
      .pop           (q_pop),
      .pop_value     (pop_value),
      .pop_pad       (pop_pad),
      .pop_ctl       (pop_ctl),
      .b_stat        (b_stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

`ifndef SYNTHESIS
   // queue occupancy stays within its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QueueCountWidth'(QueueDepth))
      else $error("job queue over its depth");

   // back end takes a job only between numbers
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> b_stat.idle)
      else $error("job popped while back end busy");

   // a taken job starts work on the next cycle
   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !b_stat.idle)
      else $error("back end stayed idle after pop");

   // idle back end never leaves a waiting job behind
   a_no_idle_wait: assert property (@(posedge clock) disable iff (reset)
      (b_stat.idle && !q_stat.empty) |-> q_pop)
      else $error("job left waiting while back end idle");
`endif

endmodule

[src/rnta_front.sv]
// ============================================================================
// rnta_front - request classification
// Takes a request beat, picks the print form (padded radix, plain decimal,
// signed decimal), works out padding, prefix and suffix, and pushes a job.
// ============================================================================
module rnta_front import rnta_pkg::*; #(
   parameter  int VALUE_WIDTH = DefaultValueWidth,
   localparam int CntWidth    = $clog2(VALUE_WIDTH + 1)
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [2:0]             req_radix_code,
   input  logic                   req_relax,
   input  logic [5:0]             req_bit_width,
   input  logic                   uppercase,
   input  syntax_style_type       syntax_style,
   input  queue_status_type       q_stat,
   output logic                   push,
   output logic [VALUE_WIDTH-1:0] push_value,
   output logic [CntWidth-1:0]    push_pad,
   output job_ctl_type            push_ctl
);

   radix_code_type         code;
   logic [4:0]             base;
   logic [4:0]             limit;
   logic                   neg;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   low_group;
   logic                   relax_plain;
   logic                   relax_signed;
   logic                   sign_neg;
   logic                   is_dec;
   logic [6:0]             bw_ext;
   logic [6:0]             bw_sat;
   logic [6:0]             oct_sum;
   logic [13:0]            oct_prod;
   job_ctl_type            ctl;
   logic [CntWidth-1:0]    pad;

   assign code      = radix_code_type'(req_radix_code);
   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      base   = base_of(code);
      limit  = relax_limit_of(code);
      neg    = req_value[VALUE_WIDTH-1];
      mag    = (~req_value) + VALUE_WIDTH'(1);
      bw_ext = {1'b0, req_bit_width};
      bw_sat = (bw_ext > 7'(VALUE_WIDTH)) ? 7'(VALUE_WIDTH) : bw_ext;
      // (bw + 2) / 3 by reciprocal, exact for bw <= 64
      oct_sum  = bw_sat + 7'd2;
      oct_prod = 14'(oct_sum) * 14'd171;

      case (code) inside
         RC_HEX, RC_OCT, RC_BIN, RC_DEC: low_group = 1'b1;
         default:                        low_group = 1'b0;
      endcase

      relax_plain  = req_relax && low_group && (req_value < VALUE_WIDTH'(base));
      relax_signed = req_relax && !low_group &&
                     (neg ? (mag < VALUE_WIDTH'(base)) : (req_value < VALUE_WIDTH'(limit)));
      sign_neg     = neg && (relax_signed || (code == RC_SDEC));
      is_dec       = relax_plain || relax_signed || (code == RC_DEC) || (code == RC_SDEC);

      ctl               = '0;
      ctl.kind          = DK_HEX;
      ctl.pre_char      = CharZero;
      ctl.post_char     = CharZero;
      pad               = '0;

      case (code) inside
         RC_HEX: begin
            pad = CntWidth'(bw_sat >> 2);
            if (syntax_style == STYLE_PREFIX) begin
               ctl.pre_valid = 1'b1;
               ctl.pre_char  = CharDollar;
            end else begin
               // leading zero only when the top digit is a letter
               ctl.pre_valid     = 1'b1;
               ctl.pre_if_letter = 1'b1;
               ctl.pre_char      = CharZero;
               ctl.post_valid    = 1'b1;
               ctl.post_char     = uppercase ? CharUpperH : CharLowerH;
            end
         end
         RC_OCT: begin
            ctl.kind = DK_OCT;
            pad      = CntWidth'(oct_prod >> 9);
            if (syntax_style == STYLE_PREFIX) begin
               ctl.pre_valid = 1'b1;
               ctl.pre_char  = CharAt;
            end else begin
               ctl.post_valid = 1'b1;
               ctl.post_char  = uppercase ? CharUpperO : CharLowerO;
            end
         end
         RC_BIN: begin
            ctl.kind = DK_BIN;
            pad      = CntWidth'(bw_sat);
            if (syntax_style == STYLE_PREFIX) begin
               ctl.pre_valid = 1'b1;
               ctl.pre_char  = CharPercent;
            end else begin
               ctl.post_valid = 1'b1;
               ctl.post_char  = uppercase ? CharUpperB : CharLowerB;
            end
         end
         RC_OCT_NP: ctl.kind = DK_OCT;
         RC_BIN_NP: ctl.kind = DK_BIN;
         default:   ctl.kind = DK_HEX;
      endcase

      if (is_dec) begin
         ctl               = '0;
         ctl.is_dec        = 1'b1;
         ctl.kind          = DK_HEX;
         ctl.pre_valid     = sign_neg;
         ctl.pre_char      = CharMinus;
         ctl.post_char     = CharZero;
         pad               = '0;
      end
   end

   assign push_value = sign_neg ? mag : req_value;
   assign push_pad   = pad;
   assign push_ctl   = ctl;

endmodule

[src/rnta_queue.sv]
// ============================================================================
// rnta_queue - job queue between front and back end
// Small FIFO of classified jobs so request intake and character output
// stall independently.
// ============================================================================
module rnta_queue import rnta_pkg::*; #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] pop_data,
   output queue_status_type      q_stat
);

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QueueDepth - 1);

   logic [DATA_WIDTH-1:0]      entry_ff [QueueDepth];
   logic [PtrWidth-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      count_in = count_ff + QueueCountWidth'(push) - QueueCountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QueueCountWidth'(QueueDepth));
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.count = count_ff;

endmodule

[src/rnta_back.sv]
// ============================================================================
// rnta_back - digit generation and character output
// Runs binary-to-BCD for decimal, splits the value into digits into the
// digit store, then reads them back most significant first, framed by the
// prefix and suffix, through a read stage and an output register.
// ============================================================================
module rnta_back import rnta_pkg::*; #(
   parameter  int VALUE_WIDTH = DefaultValueWidth,
   localparam int CntWidth    = $clog2(VALUE_WIDTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   uppercase,
   input  queue_status_type       q_stat,
   output logic                   pop,
   input  logic [VALUE_WIDTH-1:0] pop_value,
   input  logic [CntWidth-1:0]    pop_pad,
   input  job_ctl_type            pop_ctl,
   output back_status_type        b_stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CharWidth-1:0]   rsp_char_code,
   output logic                   rsp_last_char
);

   localparam int IdxWidth  = $clog2(VALUE_WIDTH);
   localparam int DecDigits = (VALUE_WIDTH * 301) / 1000 + 1;
   localparam int WorkWidth = DigitWidth * DecDigits;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_GEN,
      ST_PRE,
      ST_DIGITS,
      ST_POST
   } state_type;

   state_type              state_ff,       state_in;
   job_ctl_type            ctl_ff,         ctl_in;
   logic [CntWidth-1:0]    pad_ff,         pad_in;
   logic [VALUE_WIDTH-1:0] bin_ff,         bin_in;
   logic [WorkWidth-1:0]   work_ff,        work_in;
   logic [CntWidth-1:0]    count_ff,       count_in;
   digit_type              top_digit_ff,   top_digit_in;
   logic                   s1_valid_ff,    s1_valid_in;
   logic                   s1_is_digit_ff, s1_is_digit_in;
   char_type               s1_char_ff,     s1_char_in;
   logic                   s1_last_ff,     s1_last_in;
   logic                   rsp_valid_ff,   rsp_valid_in;
   char_type               rsp_char_ff,    rsp_char_in;
   logic                   rsp_last_ff,    rsp_last_in;

   digit_type              digit_store_ff [VALUE_WIDTH];
   digit_type              rd_data_ff;
   logic                   wr_en;
   logic [IdxWidth-1:0]    wr_addr;
   digit_type              wr_digit;
   logic                   rd_en;
   logic [IdxWidth-1:0]    rd_addr;

   logic                   s1_move;
   logic                   can_issue;
   digit_type              digit;
   logic [WorkWidth-1:0]   work_shift;
   logic [WorkWidth-1:0]   bcd_adj;
   logic [CntWidth-1:0]    count_inc;
   logic [CntWidth-1:0]    count_dec;
   logic                   has_pre;

   always_comb begin
      s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      can_issue = !s1_valid_ff || s1_move;
      count_inc = count_ff + CntWidth'(1);
      count_dec = count_ff - CntWidth'(1);
      has_pre   = ctl_ff.pre_valid &&
                  (!ctl_ff.pre_if_letter || (top_digit_ff >= LetterFirstDigit));

      case (ctl_ff.kind)
         DK_OCT: begin
            digit      = {1'b0, work_ff[2:0]};
            work_shift = work_ff >> 3;
         end
         DK_BIN: begin
            digit      = {3'b000, work_ff[0]};
            work_shift = work_ff >> 1;
         end
         default: begin
            digit      = work_ff[3:0];
            work_shift = work_ff >> 4;
         end
      endcase

      // shift-add-3 correction, each BCD digit on its own
      for (int i = 0; i < DecDigits; i++) begin
         bcd_adj[DigitWidth*i +: DigitWidth] =
            (work_ff[DigitWidth*i +: DigitWidth] >= 4'd5) ?
            work_ff[DigitWidth*i +: DigitWidth] + 4'd3 :
            work_ff[DigitWidth*i +: DigitWidth];
      end
   end

   always_comb begin
      state_in       = state_ff;
      ctl_in         = ctl_ff;
      pad_in         = pad_ff;
      bin_in         = bin_ff;
      work_in        = work_ff;
      count_in       = count_ff;
      top_digit_in   = top_digit_ff;
      s1_valid_in    = s1_valid_ff && !s1_move;
      s1_is_digit_in = s1_is_digit_ff;
      s1_char_in     = s1_char_ff;
      s1_last_in     = s1_last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      pop            = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = count_ff[IdxWidth-1:0];
      wr_digit       = digit;
      rd_en          = 1'b0;
      rd_addr        = count_dec[IdxWidth-1:0];

      // output register
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = s1_is_digit_ff ? digit_char(rd_data_ff, uppercase) : s1_char_ff;
         rsp_last_in  = s1_last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               ctl_in   = pop_ctl;
               pad_in   = pop_pad;
               count_in = '0;
               if (pop_ctl.is_dec) begin
                  bin_in   = pop_value;
                  work_in  = '0;
                  count_in = CntWidth'(VALUE_WIDTH);
                  state_in = ST_DABBLE;
               end else begin
                  work_in  = WorkWidth'(pop_value);
                  state_in = ST_GEN;
               end
            end
         end
         ST_DABBLE: begin
            work_in  = {bcd_adj[WorkWidth-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in   = bin_ff << 1;
            count_in = count_dec;
            if (count_ff == CntWidth'(1)) begin
               state_in = ST_GEN;
            end
         end
         ST_GEN: begin
            wr_en        = 1'b1;
            top_digit_in = digit;
            work_in      = work_shift;
            count_in     = count_inc;
            if ((work_shift == '0) && !(count_inc < pad_ff)) begin
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            if (!has_pre) begin
               state_in = ST_DIGITS;
            end else if (can_issue) begin
               s1_valid_in    = 1'b1;
               s1_is_digit_in = 1'b0;
               s1_char_in     = ctl_ff.pre_char;
               s1_last_in     = 1'b0;
               state_in       = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (can_issue) begin
               rd_en          = 1'b1;
               s1_valid_in    = 1'b1;
               s1_is_digit_in = 1'b1;
               s1_last_in     = (count_ff == CntWidth'(1)) && !ctl_ff.post_valid;
               count_in       = count_dec;
               if (count_ff == CntWidth'(1)) begin
                  state_in = ctl_ff.post_valid ? ST_POST : ST_IDLE;
               end
            end
         end
         ST_POST: begin
            if (can_issue) begin
               s1_valid_in    = 1'b1;
               s1_is_digit_in = 1'b0;
               s1_char_in     = ctl_ff.post_char;
               s1_last_in     = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      ctl_ff         <= ctl_in;
      pad_ff         <= pad_in;
      bin_ff         <= bin_in;
      work_ff        <= work_in;
      top_digit_ff   <= top_digit_in;
      s1_is_digit_ff <= s1_is_digit_in;
      s1_char_ff     <= s1_char_in;
      s1_last_ff     <= s1_last_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // digit store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_store_ff[wr_addr] <= wr_digit;
      end
      if (rd_en) begin
         rd_data_ff <= digit_store_ff[rd_addr];
      end
   end

   assign b_stat.idle   = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

[test/testbench.sv]
// ============================================================================
// testbench - self-checking bench for radix_number_to_ascii
// Request beats come from a queue of pending numbers and pass through a
// driver with random gaps. Each accepted number is spelled out here under the
// current register settings. A monitor with random backpressure checks every
// response beat against the oldest expected character.
// ============================================================================
module testbench;
   import rnta_pkg::*;

   localparam int ValueWidth  = 32;
   localparam int HoldTrigger = 40;     // accepted numbers before the long stall
   localparam int HoldCycles  = 600;    // length of the long receiver stall
   localparam int SettleCycles = 4;     // pause before a register write
   localparam int TailCycles  = 80;     // quiet time after the last beat
   localparam int RandomPhases = 6;
   localparam int PhaseNumbers = 60;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      radix_code_type        code;
      logic                  relax;
      logic [5:0]            width;
   } number_request_type;

   typedef struct packed {
      char_type code;
      logic     last;
   } text_beat_type;

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ValueWidth-1:0] req_value = '0;
   logic [2:0]            req_radix_code = '0;
   logic                  req_relax = 1'b0;
   logic [5:0]            req_bit_width = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CharWidth-1:0]  rsp_char_code;
   logic                  rsp_last_char;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_index = 1'b0;
   logic                  csr_write_data = 1'b0;

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   number_request_type pending_numbers [$];   // not yet offered
   text_beat_type      expected_text [$];     // characters still owed by the DUT
   digit_type          digit_scratch [ValueWidth];
   logic               letters_upper = 1'b0;  // mirror of the uppercase register
   syntax_style_type   text_style = STYLE_PREFIX;
   int unsigned        sender_idle_pct = 0;
   int unsigned        receiver_idle_pct = 0;
   int                 accepted_numbers = 0;
   int                 failures = 0;
   int                 hold_left = 0;
   logic               hold_done = 1'b0;

   radix_number_to_ascii #(.VALUE_WIDTH(ValueWidth)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_radix_code   (req_radix_code),
      .req_relax        (req_relax),
      .req_bit_width    (req_bit_width),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_code    (rsp_char_code),
      .rsp_last_char    (rsp_last_char),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Text prediction
   // ---------------------------------------------------------------------
   function automatic char_type digit_glyph(digit_type d);
      if (d < LetterFirstDigit) begin
         return char_type'(CharZero + char_type'(d));
      end
      return char_type'((letters_upper ? CharUpperA : CharLowerA) +
                        char_type'(d - LetterFirstDigit));
   endfunction

   // digits land least significant first; returns how many were made
   function automatic int unsigned spell_digits(logic [ValueWidth-1:0] x,
                                                int unsigned base, int unsigned pad);
      int unsigned n;
      logic [ValueWidth-1:0] rest;
      n = 0;
      rest = x;
      while (rest != 0 && n < ValueWidth) begin
         digit_scratch[n] = digit_type'(rest % base);
         rest = rest / base;
         n++;
      end
      if (n == 0) begin
         digit_scratch[0] = '0;
         n = 1;
      end
      while (n < pad && n < ValueWidth) begin
         digit_scratch[n] = '0;
         n++;
      end
      return n;
   endfunction

   // Spell one number under the current registers and queue its characters.
   function automatic void spell_number(number_request_type num);
      char_type              text [$];
      int unsigned           base, pad, count, width;
      logic                  negative, as_decimal, dec_negative;
      logic                  has_lead, has_tail;
      char_type              lead, tail;
      logic [ValueWidth-1:0] magnitude, dec_value;
      text_beat_type         beat;

      case (num.code)
         RC_HEX, RC_HEX_NP: base = 16;
         RC_OCT, RC_OCT_NP: base = 8;
         RC_BIN, RC_BIN_NP: base = 2;
         default:           base = 10;
      endcase
      width = (num.width > ValueWidth) ? ValueWidth : num.width;
      negative = num.value[ValueWidth-1];
      // most negative value wraps onto itself, giving 2147483648
      magnitude = negative ? (~num.value + 1'b1) : num.value;

      as_decimal = 1'b1;
      dec_negative = 1'b0;
      dec_value = num.value;
      if (num.relax && num.code <= RC_DEC && num.value < base) begin
         // small unsigned value in relaxed mode: plain decimal
      end else if (num.relax && num.code >= RC_SDEC &&
                   ((negative && magnitude < base) ||
                    (!negative && num.value < base && num.value < 10))) begin
         dec_value = magnitude;
         dec_negative = negative;
      end else if (num.code == RC_DEC) begin
         // unsigned decimal
      end else if (num.code == RC_SDEC) begin
         dec_value = magnitude;
         dec_negative = negative;
      end else begin
         as_decimal = 1'b0;
      end

      has_lead = 1'b0;
      has_tail = 1'b0;
      lead = CharZero;
      tail = CharZero;
      if (as_decimal) begin
         count = spell_digits(dec_value, 10, 0);
         has_lead = dec_negative;
         lead = CharMinus;
      end else begin
         case (num.code)
            RC_HEX:  pad = width / 4;
            RC_OCT:  pad = (width + 2) / 3;
            RC_BIN:  pad = width;
            default: pad = 0;
         endcase
         count = spell_digits(num.value, base, pad);
         if (text_style == STYLE_PREFIX) begin
            has_lead = (num.code <= RC_BIN);
            case (num.code)
               RC_HEX:  lead = CharDollar;
               RC_OCT:  lead = CharAt;
               default: lead = CharPercent;
            endcase
         end else begin
            // suffix style: hex starting with a letter gets a leading zero
            has_lead = (num.code == RC_HEX) &&
                       (digit_scratch[count-1] >= LetterFirstDigit);
            lead = CharZero;
            has_tail = (num.code <= RC_BIN);
            case (num.code)
               RC_HEX:  tail = letters_upper ? CharUpperH : CharLowerH;
               RC_OCT:  tail = letters_upper ? CharUpperO : CharLowerO;
               default: tail = letters_upper ? CharUpperB : CharLowerB;
            endcase
         end
      end

      if (has_lead) text.push_back(lead);
      for (int i = count; i > 0; i--) text.push_back(digit_glyph(digit_scratch[i-1]));
      if (has_tail) text.push_back(tail);

      foreach (text[i]) begin
         beat.code = text[i];
         beat.last = (i == text.size() - 1);
         expected_text.push_back(beat);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: keeps valid and payload steady until the beat is taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      number_request_type offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            offer.value = req_value;
            offer.code = radix_code_type'(req_radix_code);
            offer.relax = req_relax;
            offer.width = req_bit_width;
            spell_number(offer);
            accepted_numbers <= accepted_numbers + 1;
         end
         // slot is free once the current beat goes (or none was offered)
         if (!req_valid || req_ready) begin
            if (pending_numbers.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
               offer = pending_numbers.pop_front();
               req_valid <= 1'b1;
               req_value <= offer.value;
               req_radix_code <= offer.code;
               req_relax <= offer.relax;
               req_bit_width <= offer.width;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor and ready generator
   // One long stall is forced once enough numbers are in, so the job queue
   // fills up and the DUT has to hold off the sender.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      text_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected beat: char_code %h last_char %b",
                      rsp_char_code, rsp_last_char);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_code !== want.code) begin
                  $error("char_code: expected %h, actual %h", want.code, rsp_char_code);
                  failures++;
               end
               if (rsp_last_char !== want.last) begin
                  $error("last_char: expected %b, actual %b", want.last, rsp_last_char);
                  failures++;
               end
            end
         end

         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_done && accepted_numbers >= HoldTrigger) begin
            rsp_ready <= 1'b0;
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_number(logic [ValueWidth-1:0] value, radix_code_type code,
                             logic relax, logic [5:0] width);
      number_request_type num;
      num.value = value;
      num.code = code;
      num.relax = relax;
      num.width = width;
      pending_numbers.push_back(num);
   endtask

   task automatic write_register(csr_index_type idx, logic data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_UPPERCASE) letters_upper = data;
      else text_style = syntax_style_type'(data);
   endtask

   // both registers are written on every change of setting
   task automatic configure(logic upper, syntax_style_type style);
      write_register(CSR_UPPERCASE, upper);
      write_register(CSR_SYNTAX_STYLE, style);
      @(negedge clock);
   endtask

   // wait until every number has been offered, taken and fully printed
   task automatic settle();
      do @(negedge clock);
      while (pending_numbers.size() != 0 || req_valid || expected_text.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   function automatic number_request_type random_number();
      number_request_type num;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: num.value = $urandom;
         4, 5:       num.value = $urandom_range(0, 20);
         6, 7:       num.value = 32'(0 - $urandom_range(1, 20));   // small negatives
         8: begin
            case ($urandom_range(0, 3))
               0:       num.value = '0;
               1:       num.value = '1;
               2:       num.value = 32'h8000_0000;
               default: num.value = 32'h7FFF_FFFF;
            endcase
         end
         default:    num.value = $urandom >> $urandom_range(1, 31);
      endcase
      num.code = radix_code_type'($urandom_range(0, 7));
      num.relax = 1'($urandom_range(0, 1));
      // mostly legal widths, some above 32 to hit saturation
      num.width = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(33, 63))
                                              : 6'($urandom_range(0, 32));
      return num;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_sequence
      logic             phase_upper [RandomPhases];
      syntax_style_type phase_style [RandomPhases];
      phase_upper = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      phase_style = '{STYLE_PREFIX, STYLE_SUFFIX, STYLE_SUFFIX,
                      STYLE_PREFIX, STYLE_SUFFIX, STYLE_PREFIX};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sender gaps light, receiver stalls heavy
      sender_idle_pct = 19;
      receiver_idle_pct = 55;

      // directed: suffix style, upper case
      configure(1'b1, STYLE_SUFFIX);
      add_number(32'hDEAD_BEEF, RC_HEX, 1'b0, 6'd32);     // letter on top: leading 0
      add_number(32'h0000_0005, RC_HEX, 1'b0, 6'd8);
      add_number(32'hFFFF_FFFF, RC_OCT, 1'b0, 6'd32);
      add_number(32'h0000_0005, RC_BIN, 1'b0, 6'd63);     // width saturates, 33 chars
      add_number(32'h0000_0000, RC_HEX, 1'b0, 6'd0);      // zero, no padding
      add_number(32'h0000_000A, RC_HEX_NP, 1'b0, 6'd16);  // no-pad: no leading 0
      add_number(32'h8000_0000, RC_SDEC, 1'b0, 6'd32);    // most negative
      add_number(32'hFFFF_FFFF, RC_DEC, 1'b0, 6'd32);
      add_number(32'h0000_000F, RC_HEX, 1'b1, 6'd32);     // relaxed below base
      add_number(32'hFFFF_FFF7, RC_SDEC, 1'b1, 6'd32);    // relaxed -9
      add_number(32'hFFFF_FFFF, RC_BIN_NP, 1'b1, 6'd32);  // relaxed -1
      add_number(32'h0000_0000, RC_OCT_NP, 1'b0, 6'd12);
      settle();

      // directed: prefix style, lower case
      configure(1'b0, STYLE_PREFIX);
      add_number(32'hABCD_EF01, RC_HEX, 1'b0, 6'd32);
      add_number(32'h0000_0008, RC_OCT, 1'b1, 6'd9);      // at base: not relaxed
      add_number(32'h0000_0001, RC_BIN, 1'b1, 6'd4);
      add_number(32'h0000_0002, RC_BIN, 1'b0, 6'd4);
      add_number(32'h0000_0000, RC_DEC, 1'b0, 6'd0);
      add_number(32'h7FFF_FFFF, RC_SDEC, 1'b1, 6'd32);
      add_number(32'h0000_0009, RC_OCT_NP, 1'b1, 6'd0);   // 9 is past the octal base
      add_number(32'h0000_000A, RC_SDEC, 1'b1, 6'd32);    // relaxed range is open
      add_number(32'hFFFF_FFF6, RC_SDEC, 1'b1, 6'd32);
      add_number(32'hFFFF_FFFF, RC_BIN_NP, 1'b0, 6'd0);   // negative as bit pattern
      add_number(32'h0000_0001, RC_HEX, 1'b0, 6'd33);
      add_number(32'h0000_0000, RC_SDEC, 1'b0, 6'd5);
      settle();

      // random phases; gap pattern flips after two, then no gaps at all
      for (int p = 0; p < RandomPhases; p++) begin
         if (p == 2) begin
            sender_idle_pct = 55;
            receiver_idle_pct = 19;
         end else if (p == 4) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         configure(phase_upper[p], phase_style[p]);
         repeat (PhaseNumbers) pending_numbers.push_back(random_number());
         settle();
      end

      repeat (TailCycles) @(negedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
